// ----- sv/allpass_chain_phaser_core_assert.svh -----
// assertion macros shared by the phaser rtl
`ifndef ALLPASS_CHAIN_PHASER_CORE_ASSERT_SVH
`define ALLPASS_CHAIN_PHASER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, off while reset is low
`define APC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("apc assertion failed");

// next-cycle implication, off while reset is low
`define APC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("apc assertion failed");

`else

`define APC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define APC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- sv/apc_pkg.sv -----
// shared constants, types and helpers for the allpass chain phaser
package apc_pkg;

    localparam int STAGES       = 10;

    localparam int SAMPLE_W     = 24;
    localparam int MOD_VALUE_W  = 16;
    localparam int MOD_SCALE_W  = 32;
    localparam int MOD_OFFSET_W = 31;
    localparam int TIME_STEP_W  = 31;
    localparam int OUT_GAIN_W   = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;

    // pole term arithmetic, 46 fraction bits
    localparam int POLE_SHIFT   = 16;
    localparam int MPROD_W      = MOD_SCALE_W + 1 + MOD_VALUE_W;
    localparam int NUM_W        = MPROD_W + 1;
    localparam int MAG_W        = NUM_W - 1;

    // coefficient, 30 fraction bits, range [-1, 1]
    localparam int COEF_FRAC    = 30;
    localparam int COEF_W       = COEF_FRAC + 2;
    localparam int DIV_CNT_W    = $clog2(COEF_FRAC);

    // allpass cell arithmetic
    localparam int SUM_W        = SAMPLE_W + 1;
    localparam int PROD_W       = COEF_W + SUM_W;
    localparam int TRUNC_W      = PROD_W - COEF_FRAC;
    localparam int DIFF_W       = TRUNC_W + 1;

    // output gain, 12 fraction bits
    localparam int GAIN_FRAC    = 12;
    localparam int OPROD_W      = OUT_GAIN_W + 1 + SUM_W;
    localparam int OTRUNC_W     = OPROD_W - GAIN_FRAC;

    localparam int SAT_IN_W     = 32;

    localparam logic [MOD_SCALE_W-1:0]  MOD_SCALE_RST  = MOD_SCALE_W'(1073775);
    localparam logic [MOD_OFFSET_W-1:0] MOD_OFFSET_RST = MOD_OFFSET_W'(7186554);
    localparam logic [TIME_STEP_W-1:0]  TIME_STEP_RST  = TIME_STEP_W'(22369);
    localparam logic [OUT_GAIN_W-1:0]   OUT_GAIN_RST   = OUT_GAIN_W'(2867);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    localparam coef_t COEF_ONE = coef_t'(longint'(1) << COEF_FRAC);

    localparam logic signed [SAT_IN_W-1:0] SAT_HI =
        SAT_IN_W'((longint'(1) << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

    // one sample moving from a cell to its right neighbor
    typedef struct packed {
        logic    valid;
        sample_t x;
        sample_t xprev;
    } cell_link_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MOD_SCALE  = 3'd0,
        CFG_MOD_OFFSET = 3'd1,
        CFG_TIME_STEP  = 3'd2,
        CFG_OUT_GAIN   = 3'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_RR,
        ST_ND,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LAUNCH,
        ST_CHAIN_WAIT,
        ST_OMUL,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_CHECK,
        DIV_RUN,
        DIV_SIGN
    } div_state_t;

    function automatic sample_t sat_sample(input logic signed [SAT_IN_W-1:0] v);
        sample_t r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/apc_div.sv -----
// bit-serial signed divider producing the saturated allpass coefficient
`include "allpass_chain_phaser_core_assert.svh"

module apc_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [apc_pkg::NUM_W-1:0]    num,
    input  logic signed [apc_pkg::NUM_W-1:0]    den,
    output logic                                done,
    output apc_pkg::coef_t                      quot
);
    import apc_pkg::*;

    localparam logic [COEF_FRAC:0] MAG_ONE = {1'b1, {COEF_FRAC{1'b0}}};

    div_state_t               state_reg, state_next;
    logic [MAG_W-1:0]         n_reg;
    logic [MAG_W-1:0]         d_reg;
    logic                     num_neg_reg;
    logic                     den_neg_reg;
    logic                     neg_reg;
    logic [COEF_FRAC-1:0]     q_reg;
    logic [COEF_FRAC:0]       mag_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;

    logic [NUM_W-1:0]         num_abs;
    logic [NUM_W-1:0]         den_abs;
    logic [MAG_W:0]           rem_shift;
    logic [MAG_W:0]           d_ext;
    logic [MAG_W:0]           rem_diff;
    logic                     rem_ge;
    logic [MAG_W-1:0]         n_step;
    logic [COEF_FRAC-1:0]     q_step;
    coef_t                    mag_ext;

    always_comb begin
        num_abs   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den_abs   = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
        rem_shift = {n_reg, 1'b0};
        d_ext     = {1'b0, d_reg};
        rem_diff  = rem_shift - d_ext;
        rem_ge    = rem_shift >= d_ext;
        n_step    = rem_ge ? rem_diff[MAG_W-1:0] : rem_shift[MAG_W-1:0];
        q_step    = {q_reg[COEF_FRAC-2:0], rem_ge};
        mag_ext   = coef_t'({1'b0, mag_reg});
        quot      = neg_reg ? -mag_ext : mag_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    state_next = DIV_CHECK;
                end
            end
            DIV_CHECK: begin
                // |num| >= |den| covers the zero divisor too
                if (n_reg >= d_reg) begin
                    state_next = DIV_SIGN;
                end else begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (cnt_reg == DIV_CNT_W'(COEF_FRAC - 1)) begin
                    state_next = DIV_SIGN;
                end
            end
            DIV_SIGN: begin
                done       = 1'b1;
                state_next = DIV_IDLE;
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    n_reg       <= num_abs[MAG_W-1:0];
                    d_reg       <= den_abs[MAG_W-1:0];
                    num_neg_reg <= num[NUM_W-1];
                    den_neg_reg <= den[NUM_W-1];
                end
            end
            DIV_CHECK: begin
                cnt_reg <= '0;
                q_reg   <= '0;
                if (d_reg == '0) begin
                    // zero divisor: sign of the numerator, zero over zero is zero
                    neg_reg <= num_neg_reg;
                    mag_reg <= (n_reg == '0) ? '0 : MAG_ONE;
                end else begin
                    neg_reg <= num_neg_reg ^ den_neg_reg;
                    mag_reg <= MAG_ONE;
                end
            end
            DIV_RUN: begin
                n_reg   <= n_step;
                q_reg   <= q_step;
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                mag_reg <= {1'b0, q_step};
            end
            default: begin
            end
        endcase
    end

    `APC_ASSERT_IMP(a_div_start_idle, aclk, aresetn, start, state_reg == DIV_IDLE)
    `APC_ASSERT_IMP(a_div_quot_range, aclk, aresetn, done, (quot <= COEF_ONE) && (quot >= -COEF_ONE))
    `APC_ASSERT_NXT(a_div_done_pulse, aclk, aresetn, done, !done)

endmodule

// ----- sv/apc_cell.sv -----
// one first-order allpass cell of the phaser chain
module apc_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  apc_pkg::coef_t        coef,
    input  apc_pkg::cell_link_t   link_in,
    output apc_pkg::cell_link_t   link_out
);
    import apc_pkg::*;

    logic                         a_valid_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    sample_t                      xprev_a_reg;
    sample_t                      y_hist_reg;
    logic                         out_valid_reg;
    sample_t                      out_x_reg;
    sample_t                      out_xprev_reg;

    logic signed [SUM_W-1:0]      sum_in;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [PROD_W-1:0]     prod_adj;
    logic signed [TRUNC_W-1:0]    trunc_val;
    logic signed [DIFF_W-1:0]     diff;
    sample_t                      y_next;

    always_comb begin
        sum_in    = SUM_W'(link_in.x) + SUM_W'(y_hist_reg);
        prod_next = coef * sum_in;
        // bias negatives so the arithmetic shift truncates toward zero
        prod_adj  = prod_reg +
                    $signed({{(PROD_W-COEF_FRAC){1'b0}}, {COEF_FRAC{prod_reg[PROD_W-1]}}});
        trunc_val = prod_adj[PROD_W-1:COEF_FRAC];
        diff      = DIFF_W'(trunc_val) - DIFF_W'(xprev_a_reg);
        y_next    = sat_sample(SAT_IN_W'(diff));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            y_hist_reg    <= '0;
        end else begin
            a_valid_reg   <= link_in.valid;
            out_valid_reg <= a_valid_reg;
            if (a_valid_reg) begin
                y_hist_reg <= y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (link_in.valid) begin
            prod_reg    <= prod_next;
            xprev_a_reg <= link_in.xprev;
        end
        if (a_valid_reg) begin
            out_x_reg     <= y_next;
            // the next cell subtracts this cell's previous output
            out_xprev_reg <= y_hist_reg;
        end
    end

    always_comb begin
        link_out.valid = out_valid_reg;
        link_out.x     = out_x_reg;
        link_out.xprev = out_xprev_reg;
    end

endmodule

// ----- sv/allpass_chain_phaser_core.sv -----
// top level of the allpass chain phaser: control, coefficient path, cell chain, output
//
// channel  dir  signals                                   transaction
// s_       in   s_valid s_ready s_sample_in s_mod_value   one sample and modulator value
// m_       out  m_valid m_ready m_sample_out              one phased sample
// cfg_     in   cfg_valid cfg_ready cfg_index cfg_data    one register write
//
// per sample: take it, form the pole term, run the divider (one quotient bit per cycle, the
// bit loop skipped when the coefficient saturates), launch, pass the allpass cells, finish
// one sample is in flight at a time; the next is taken once the previous result sits
// in the output register, and a stalled m_ready holds the block before that register
// cfg_ready stays high; reset clears cell histories, previous input and registers

`include "allpass_chain_phaser_core_assert.svh"

module allpass_chain_phaser_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [apc_pkg::SAMPLE_W-1:0]   s_sample_in,
    input  logic signed [apc_pkg::MOD_VALUE_W-1:0] s_mod_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [apc_pkg::SAMPLE_W-1:0]   m_sample_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [apc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [apc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import apc_pkg::*;

    ctrl_state_t                      state_reg, state_next;

    logic [MOD_SCALE_W-1:0]           mod_scale_reg;
    logic [MOD_OFFSET_W-1:0]          mod_offset_reg;
    logic [TIME_STEP_W-1:0]           time_step_reg;
    logic [OUT_GAIN_W-1:0]            out_gain_reg;

    sample_t                          sample_reg;
    logic signed [MOD_VALUE_W-1:0]    mod_value_reg;
    logic signed [MPROD_W-1:0]        mprod_reg;
    logic signed [NUM_W-1:0]          rr_reg;
    logic signed [NUM_W-1:0]          num_reg;
    logic signed [NUM_W-1:0]          den_reg;
    coef_t                            coef_reg;
    sample_t                          prev_in_reg;
    logic signed [SUM_W-1:0]          osum_reg;
    logic signed [OPROD_W-1:0]        oprod_reg;
    logic                             m_valid_reg;
    sample_t                          m_sample_out_reg;

    logic                             in_take;
    logic                             div_start;
    logic                             launch;
    logic                             out_load;
    logic                             div_done;
    coef_t                            div_quot;
    logic                             chain_done;

    logic signed [NUM_W-1:0]          offset_term;
    logic signed [NUM_W-1:0]          dt_term;
    logic signed [MPROD_W-1:0]        mprod_next;
    logic signed [OPROD_W-1:0]        oprod_next;
    logic signed [OPROD_W-1:0]        oprod_adj;
    logic signed [OTRUNC_W-1:0]       otrunc;
    sample_t                          out_sat;

    cell_link_t                       chain_link [STAGES+1];

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        launch     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_RR;
            ST_RR:     state_next = ST_ND;
            ST_ND:     state_next = ST_DIV_GO;
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                launch     = 1'b1;
                state_next = ST_CHAIN_WAIT;
            end
            ST_CHAIN_WAIT: begin
                if (chain_done) begin
                    state_next = ST_OMUL;
                end
            end
            ST_OMUL:   state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_take    = s_valid && s_ready;
    assign chain_done = chain_link[STAGES].valid;

    // configuration and reset-cleared state
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_scale_reg  <= MOD_SCALE_RST;
            mod_offset_reg <= MOD_OFFSET_RST;
            time_step_reg  <= TIME_STEP_RST;
            out_gain_reg   <= OUT_GAIN_RST;
            prev_in_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MOD_SCALE:  mod_scale_reg  <= cfg_data[MOD_SCALE_W-1:0];
                    CFG_MOD_OFFSET: mod_offset_reg <= cfg_data[MOD_OFFSET_W-1:0];
                    CFG_TIME_STEP:  time_step_reg  <= cfg_data[TIME_STEP_W-1:0];
                    CFG_OUT_GAIN:   out_gain_reg   <= cfg_data[OUT_GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_CHAIN_WAIT && chain_done) begin
                prev_in_reg <= sample_reg;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // coefficient path: rr = scale*mod + offset, num = rr - dt, den = rr + dt
    always_comb begin
        offset_term = $signed({{(NUM_W-MOD_OFFSET_W-POLE_SHIFT){1'b0}},
                               mod_offset_reg, {POLE_SHIFT{1'b0}}});
        dt_term     = $signed({{(NUM_W-TIME_STEP_W-POLE_SHIFT){1'b0}},
                               time_step_reg, {POLE_SHIFT{1'b0}}});
        mprod_next  = $signed({1'b0, mod_scale_reg}) * mod_value_reg;
        oprod_next  = $signed({1'b0, out_gain_reg}) * osum_reg;
        oprod_adj   = oprod_reg +
                      $signed({{(OPROD_W-GAIN_FRAC){1'b0}}, {GAIN_FRAC{oprod_reg[OPROD_W-1]}}});
        otrunc      = oprod_adj[OPROD_W-1:GAIN_FRAC];
        out_sat     = sat_sample(SAT_IN_W'(otrunc));
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            sample_reg    <= s_sample_in;
            mod_value_reg <= s_mod_value;
        end
        case (state_reg)
            ST_MUL: mprod_reg <= mprod_next;
            ST_RR:  rr_reg    <= NUM_W'(mprod_reg) + offset_term;
            ST_ND: begin
                num_reg <= rr_reg - dt_term;
                den_reg <= rr_reg + dt_term;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    coef_reg <= div_quot;
                end
            end
            ST_CHAIN_WAIT: begin
                if (chain_done) begin
                    osum_reg <= SUM_W'(sample_reg) + SUM_W'(chain_link[STAGES].x);
                end
            end
            ST_OMUL: oprod_reg <= oprod_next;
            default: begin
            end
        endcase
        if (out_load) begin
            m_sample_out_reg <= out_sat;
        end
    end

    apc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // cell chain, the first cell sees the dry sample and the previous input
    always_comb begin
        chain_link[0].valid = launch;
        chain_link[0].x     = sample_reg;
        chain_link[0].xprev = prev_in_reg;
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        apc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .coef     (coef_reg),
            .link_in  (chain_link[g]),
            .link_out (chain_link[g+1])
        );
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

    `APC_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, in_take, !s_ready)
    `APC_ASSERT_IMP(a_chain_end_expected, aclk, aresetn, chain_done, state_reg == ST_CHAIN_WAIT)
    `APC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_out))

endmodule
